// ===== src/skst_pkg.sv =====
// ----------------------------------------------------------------------------
// skst_pkg
// Shared types and constants of the saturating kernel stamp unit.
// ----------------------------------------------------------------------------
package skst_pkg;

    localparam int DIM_W   = 9;
    localparam int COORD_W = DIM_W + 1;
    localparam int HALF_W  = 5;
    localparam int SIDE_W  = HALF_W + 1;
    localparam int BYTE_W  = 8;
    localparam int KIDX_W  = 12;
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 9;

    typedef enum logic [1:0] {
        CMD_KERNEL_WR = 2'd0,
        CMD_CELL_WR   = 2'd1,
        CMD_CELL_RD   = 2'd2,
        CMD_STAMP     = 2'd3
    } cmd_t;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CEILING     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd4;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef struct packed {
        logic              enable;
        logic [HALF_W-1:0] half_width;
        logic [BYTE_W-1:0] ceiling;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } cfg_t;

endpackage

// ===== src/skst_cfg_if.sv =====
// ----------------------------------------------------------------------------
// skst_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface skst_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/skst_cmd_if.sv =====
// ----------------------------------------------------------------------------
// skst_cmd_if
// Command channel: one command item per handshake.
// ----------------------------------------------------------------------------
interface skst_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [11:0] kernel_index;
    logic [7:0]  value;

    modport source (output valid, output command, output cell_col, output cell_row,
                    output kernel_index, output value, input ready);
    modport sink   (input valid, input command, input cell_col, input cell_row,
                    input kernel_index, input value, output ready);
endinterface

// ===== src/skst_res_if.sv =====
// ----------------------------------------------------------------------------
// skst_res_if
// Result channel: one result item per command.
// ----------------------------------------------------------------------------
interface skst_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic       status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// ===== src/saturating_kernel_stamp_unit.sv =====
// ----------------------------------------------------------------------------
// saturating_kernel_stamp_unit
// Byte cost grid with a square kernel that is added in, clamped, per stamp.
//
//   channel  dir  handshake      payload
//   cfg      in   valid/ready    index, data
//   cmd      in   valid/ready    command, cell_col, cell_row, kernel_index, value
//   res      out  valid/ready    read_value, status
//
// Kernel write, cell write, rejected commands and disabled stamps pass the
// decode and done steps before the result; a cell read adds a read step.
// A stamp steps through the (2*h+1)^2 kernel cells, then drains: the grid and
// kernel memories are read once per kernel cell and the grid is written back in the next cycle.
// One command is in work at a time; a finished item waits in the output
// register while the next command is accepted. Reset leaves both memories
// undefined and sets the registers to their defaults; cfg is always ready.
// ----------------------------------------------------------------------------
module saturating_kernel_stamp_unit #(
    parameter int GRID_SIDE      = 256,
    parameter int MAX_HALF_WIDTH = 31
) (
    input  logic       clk,
    input  logic       rst_n,
    skst_cfg_if.sink   cfg,
    skst_cmd_if.sink   cmd,
    skst_res_if.source res
);

    import skst_pkg::*;

    localparam int KDEPTH = (2 * MAX_HALF_WIDTH + 1) * (2 * MAX_HALF_WIDTH + 1);
    localparam int KAW    = $clog2(KDEPTH);
    localparam int GDEPTH = GRID_SIDE * GRID_SIDE;
    localparam int GAW    = $clog2(GDEPTH);

    cfg_t           cfg_val;
    logic           grid_we;
    logic [GAW-1:0] grid_waddr;
    logic [7:0]     grid_wdata;
    logic [GAW-1:0] grid_raddr;
    logic [7:0]     grid_rdata;
    logic           kern_we;
    logic [KAW-1:0] kern_waddr;
    logic [7:0]     kern_wdata;
    logic [KAW-1:0] kern_raddr;
    logic [7:0]     kern_rdata;

    skst_cfg_regs #(
        .GRID_SIDE      (GRID_SIDE),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    skst_seq #(
        .GRID_SIDE      (GRID_SIDE),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_val    (cfg_val),
        .cmd        (cmd),
        .res        (res),
        .grid_we    (grid_we),
        .grid_waddr (grid_waddr),
        .grid_wdata (grid_wdata),
        .grid_raddr (grid_raddr),
        .grid_rdata (grid_rdata),
        .kern_we    (kern_we),
        .kern_waddr (kern_waddr),
        .kern_wdata (kern_wdata),
        .kern_raddr (kern_raddr),
        .kern_rdata (kern_rdata)
    );

    skst_ram #(
        .WIDTH (8),
        .DEPTH (GDEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    skst_ram #(
        .WIDTH (8),
        .DEPTH (KDEPTH)
    ) u_kern_ram (
        .clk   (clk),
        .we    (kern_we),
        .waddr (kern_waddr),
        .wdata (kern_wdata),
        .raddr (kern_raddr),
        .rdata (kern_rdata)
    );

endmodule

// ===== src/skst_ram.sv =====
// ----------------------------------------------------------------------------
// skst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/skst_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// skst_cfg_regs
// Configuration registers and their saturated working values.
// ----------------------------------------------------------------------------
module skst_cfg_regs #(
    parameter int GRID_SIDE      = 256,
    parameter int MAX_HALF_WIDTH = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    skst_cfg_if.sink      cfg,
    output skst_pkg::cfg_t cfg_val
);

    import skst_pkg::*;

    localparam int SIDE_CAP = (GRID_SIDE > 511) ? 511 : GRID_SIDE;
    localparam int HW_CAP   = (MAX_HALF_WIDTH > 31) ? 31 : MAX_HALF_WIDTH;
    localparam logic [DIM_W-1:0]  SIDE_CAP_V = DIM_W'(SIDE_CAP);
    localparam logic [HALF_W-1:0] HW_CAP_V   = HALF_W'(HW_CAP);

    logic              enable_reg;
    logic [HALF_W-1:0] half_width_reg;
    logic [BYTE_W-1:0] ceiling_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            half_width_reg <= '0;
            ceiling_reg    <= 8'd254;
            width_reg      <= 9'd256;
            height_reg     <= 9'd256;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ENABLE:      enable_reg     <= cfg.data[0];
                REG_HALF_WIDTH:  half_width_reg <= cfg.data[HALF_W-1:0];
                REG_CEILING:     ceiling_reg    <= cfg.data[BYTE_W-1:0];
                REG_GRID_WIDTH:  width_reg      <= cfg.data[DIM_W-1:0];
                REG_GRID_HEIGHT: height_reg     <= cfg.data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg_val.enable     = enable_reg;
        cfg_val.half_width = (half_width_reg > HW_CAP_V) ? HW_CAP_V : half_width_reg;
        cfg_val.ceiling    = ceiling_reg;
        cfg_val.width      = (width_reg > SIDE_CAP_V) ? SIDE_CAP_V : width_reg;
        cfg_val.height     = (height_reg > SIDE_CAP_V) ? SIDE_CAP_V : height_reg;
    end

endmodule

// ===== src/skst_seq.sv =====
// ----------------------------------------------------------------------------
// skst_seq
// Command sequencer: decodes items, drives the grid and kernel memories,
// and runs the read-add-clamp-write pass of a stamp one cell per cycle.
// ----------------------------------------------------------------------------
module skst_seq #(
    parameter int GRID_SIDE      = 256,
    parameter int MAX_HALF_WIDTH = 31,
    localparam int KDEPTH = (2 * MAX_HALF_WIDTH + 1) * (2 * MAX_HALF_WIDTH + 1),
    localparam int KAW    = $clog2(KDEPTH),
    localparam int GAW    = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  skst_pkg::cfg_t cfg_val,
    skst_cmd_if.sink       cmd,
    skst_res_if.source     res,
    output logic           grid_we,
    output logic [GAW-1:0] grid_waddr,
    output logic [7:0]     grid_wdata,
    output logic [GAW-1:0] grid_raddr,
    input  logic [7:0]     grid_rdata,
    output logic           kern_we,
    output logic [KAW-1:0] kern_waddr,
    output logic [7:0]     kern_wdata,
    output logic [KAW-1:0] kern_raddr,
    input  logic [7:0]     kern_rdata
);

    import skst_pkg::*;

    localparam logic [GAW-1:0] SIDE_G = GAW'(GRID_SIDE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_STAMP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [KIDX_W-1:0]  kidx_reg, kidx_next;
    logic [BYTE_W-1:0]  val_reg, val_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_base_reg, col_base_next;
    logic [SIDE_W-1:0]  x_reg, x_next;
    logic [SIDE_W-1:0]  y_reg, y_next;
    logic [KAW-1:0]     kaddr_reg, kaddr_next;
    logic               p_valid_reg, p_valid_next;
    logic               p_wr_reg, p_wr_next;
    logic [GAW-1:0]     p_addr_reg, p_addr_next;
    logic [BYTE_W-1:0]  rvalue_reg, rvalue_next;
    logic               status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_value_reg, out_value_next;
    logic               out_status_reg, out_status_next;

    logic               pos_ok;
    logic [GAW-1:0]     cur_addr;
    logic [COORD_W-1:0] h_ext;
    logic [SIDE_W-1:0]  last_pos;
    logic               kern_ok;
    logic [BYTE_W:0]    sum;
    logic [BYTE_W-1:0]  clamped;
    logic               out_free;

    assign pos_ok = !col_reg[COORD_W-1] && !row_reg[COORD_W-1]
                 && (col_reg[COORD_W-2:0] < cfg_val.width)
                 && (row_reg[COORD_W-2:0] < cfg_val.height);
    assign cur_addr = GAW'(row_reg) * SIDE_G + GAW'(col_reg);
    assign h_ext    = COORD_W'(cfg_val.half_width);
    assign last_pos = {cfg_val.half_width, 1'b0};
    assign kern_ok  = int'(kidx_reg) < KDEPTH;
    assign sum      = {1'b0, grid_rdata} + {1'b0, kern_rdata};
    assign clamped  = (sum > {1'b0, cfg_val.ceiling}) ? cfg_val.ceiling : sum[BYTE_W-1:0];
    assign out_free = !out_valid_reg || res.ready;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.read_value = out_value_reg;
    assign res.status     = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        kidx_next       = kidx_reg;
        val_next        = val_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        col_base_next   = col_base_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        kaddr_next      = kaddr_reg;
        p_valid_next    = 1'b0;
        p_wr_next       = pos_ok;
        p_addr_next     = cur_addr;
        rvalue_next     = rvalue_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        grid_we    = p_valid_reg && p_wr_reg;
        grid_waddr = p_addr_reg;
        grid_wdata = clamped;
        grid_raddr = cur_addr;
        kern_we    = 1'b0;
        kern_waddr = KAW'(kidx_reg);
        kern_wdata = val_reg;
        kern_raddr = kaddr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd_t'(cmd.command);
                    kidx_next  = cmd.kernel_index;
                    val_next   = cmd.value;
                    col_next   = COORD_W'(cmd.cell_col);
                    row_next   = COORD_W'(cmd.cell_row);
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                status_next = STATUS_DONE;
                rvalue_next = '0;
                state_next  = ST_DONE;
                if (cmd_reg == CMD_KERNEL_WR)
                begin
                    if (kern_ok)
                    begin
                        kern_we = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_OUTSIDE;
                    end
                end
                else if (!pos_ok)
                begin
                    status_next = STATUS_OUTSIDE;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_CELL_WR:
                        begin
                            grid_we    = 1'b1;
                            grid_waddr = cur_addr;
                            grid_wdata = val_reg;
                        end
                        CMD_CELL_RD:
                        begin
                            state_next = ST_READ;
                        end
                        CMD_STAMP:
                        begin
                            if (cfg_val.enable)
                            begin
                                col_next      = col_reg - h_ext;
                                row_next      = row_reg - h_ext;
                                col_base_next = col_reg - h_ext;
                                x_next        = '0;
                                y_next        = '0;
                                kaddr_next    = '0;
                                state_next    = ST_STAMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                rvalue_next = grid_rdata;
                state_next  = ST_DONE;
            end
            ST_STAMP:
            begin
                p_valid_next = 1'b1;
                kaddr_next   = kaddr_reg + KAW'(1);
                if (x_reg == last_pos)
                begin
                    x_next   = '0;
                    col_next = col_base_reg;
                    if (y_reg == last_pos)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        y_next   = y_reg + SIDE_W'(1);
                        row_next = row_reg + COORD_W'(1);
                    end
                end
                else
                begin
                    x_next   = x_reg + SIDE_W'(1);
                    col_next = col_reg + COORD_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rvalue_reg;
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_KERNEL_WR;
            kidx_reg       <= '0;
            val_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            col_base_reg   <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            kaddr_reg      <= '0;
            p_valid_reg    <= 1'b0;
            p_wr_reg       <= 1'b0;
            p_addr_reg     <= '0;
            rvalue_reg     <= '0;
            status_reg     <= STATUS_DONE;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            kidx_reg       <= kidx_next;
            val_reg        <= val_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            col_base_reg   <= col_base_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            kaddr_reg      <= kaddr_next;
            p_valid_reg    <= p_valid_next;
            p_wr_reg       <= p_wr_next;
            p_addr_reg     <= p_addr_next;
            rvalue_reg     <= rvalue_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    a_pipe_in_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == ST_STAMP || state_reg == ST_DRAIN))
        else $error("stamp write-back outside of a stamp pass");

    a_kaddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STAMP) |-> (int'(kaddr_reg) < KDEPTH))
        else $error("kernel address beyond store");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_wr_reg) |-> (grid_wdata <= cfg_val.ceiling))
        else $error("stamped cell above ceiling");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !res.ready)) |->
            ($past(state_reg) == ST_DONE))
        else $error("result item loaded outside the done step");

endmodule

// ===== tb/skst_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// skst_tb_pkg
// Mirror of the cost grid and kernel for the stamp unit testbench. It keeps
// its own copy of both memories and of the register settings, works out the
// result of each accepted command and matches results in arrival order.
// ----------------------------------------------------------------------------
package skst_tb_pkg;

    import skst_pkg::*;

    localparam int GRID_SIDE      = 256;
    localparam int MAX_HALF_WIDTH = 31;
    localparam int KERNEL_SIDE    = 2 * MAX_HALF_WIDTH + 1;
    localparam int KERNEL_DEPTH   = KERNEL_SIDE * KERNEL_SIDE;
    localparam int GRID_DEPTH     = GRID_SIDE * GRID_SIDE;

    typedef struct packed {
        logic [BYTE_W-1:0] read_value;
        logic              status;
    } stamp_result_t;

    class cost_grid_mirror;

        logic [BYTE_W-1:0] cost_mem [GRID_DEPTH];
        bit                cell_known [GRID_DEPTH];
        logic [BYTE_W-1:0] kernel_mem [KERNEL_DEPTH];
        bit                tap_known [KERNEL_DEPTH];

        logic              enable;
        logic [HALF_W-1:0] half_width;
        logic [BYTE_W-1:0] ceiling;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;

        int window_taps[$];
        int window_cells[$];

        stamp_result_t due_results[$];
        int            mismatches;

        function new();
            enable     = 1'b1;
            half_width = '0;
            ceiling    = 8'd254;
            width      = 9'd256;
            height     = 9'd256;
            mismatches = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE:      enable     = data[0];
                REG_HALF_WIDTH:  half_width = data[HALF_W-1:0];
                REG_CEILING:     ceiling    = data[BYTE_W-1:0];
                REG_GRID_WIDTH:  width      = data;
                REG_GRID_HEIGHT: height     = data;
                default: ;
            endcase
        endfunction

        function int cols_in_use();
            return (int'(width) > GRID_SIDE) ? GRID_SIDE : int'(width);
        endfunction

        function int rows_in_use();
            return (int'(height) > GRID_SIDE) ? GRID_SIDE : int'(height);
        endfunction

        function bit in_grid(int col, int row);
            return col < cols_in_use() && row < rows_in_use();
        endfunction

        // collect the kernel taps and grid cells a stamp at (col, row) touches
        function void map_window(int col, int row);
            int h;
            int side;
            int r;
            int c;
            int x;
            int y;
            h    = int'(half_width);
            side = 2 * h + 1;
            window_taps.delete();
            window_cells.delete();
            for (y = 0; y < side; y++)
            begin
                r = row - h + y;
                if (r < 0 || r >= rows_in_use())
                    continue;
                for (x = 0; x < side; x++)
                begin
                    c = col - h + x;
                    if (c < 0 || c >= cols_in_use())
                        continue;
                    window_taps  = {window_taps, x + side * y};
                    window_cells = {window_cells, r * GRID_SIDE + c};
                end
            end
        endfunction

        function void note_command(cmd_t op, logic [7:0] col, logic [7:0] row,
                                   logic [KIDX_W-1:0] kidx, logic [BYTE_W-1:0] val);
            stamp_result_t res;
            int            gi;
            int            sum;
            res.read_value = '0;
            res.status     = STATUS_DONE;
            gi = int'(row) * GRID_SIDE + int'(col);
            if (op == CMD_KERNEL_WR)
            begin
                if (int'(kidx) < KERNEL_DEPTH)
                begin
                    kernel_mem[kidx] = val;
                    tap_known[kidx]  = 1'b1;
                end
                else
                    res.status = STATUS_OUTSIDE;
            end
            else if (!in_grid(int'(col), int'(row)))
                res.status = STATUS_OUTSIDE;
            else if (op == CMD_CELL_WR)
            begin
                cost_mem[gi]   = val;
                cell_known[gi] = 1'b1;
            end
            else if (op == CMD_CELL_RD)
                res.read_value = cost_mem[gi];
            else if (enable)
            begin
                map_window(int'(col), int'(row));
                foreach (window_cells[i])
                begin
                    sum = int'(cost_mem[window_cells[i]]) + int'(kernel_mem[window_taps[i]]);
                    if (sum > int'(ceiling))
                        sum = int'(ceiling);
                    cost_mem[window_cells[i]] = sum[BYTE_W-1:0];
                end
            end
            due_results = {due_results, res};
        endfunction

        function void check_result(logic [BYTE_W-1:0] rd, logic st);
            stamp_result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: read_value=%0h status=%0b", rd, st);
                return;
            end
            want = due_results.pop_front();
            if (rd !== want.read_value || st !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected read_value=%0h status=%0b, got read_value=%0h status=%0b",
                             want.read_value, want.status, rd, st);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

    endclass

endpackage

// ===== tb/tb_saturating_kernel_stamp_unit.sv =====
// ----------------------------------------------------------------------------
// tb_saturating_kernel_stamp_unit
// Drives kernel writes, cell writes, cell reads and stamps into the stamp
// unit under a range of register settings, and checks every result item
// against a mirror of the grid. Directed items cover the field extremes and
// corner cases; random phases follow, with random idling on both sides but the last.
// ----------------------------------------------------------------------------
module tb_saturating_kernel_stamp_unit;

    import skst_pkg::*;
    import skst_tb_pkg::*;

    localparam int STALL_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 4000;
    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 16;

    logic clk;
    logic rst_n;
    bit   idling;

    skst_cfg_if cfg();
    skst_cmd_if cmd();
    skst_res_if res();

    saturating_kernel_stamp_unit #(
        .GRID_SIDE      (GRID_SIDE),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .res   (res)
    );

    cost_grid_mirror mirror = new();

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_cmd(input cmd_t op, input logic [7:0] col, input logic [7:0] row,
                            input logic [KIDX_W-1:0] kidx, input logic [BYTE_W-1:0] val);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.command      <= op;
        cmd.cell_col     <= col;
        cmd.cell_row     <= row;
        cmd.kernel_index <= kidx;
        cmd.value        <= val;
        @(posedge clk);
        while (cmd.ready !== 1'b1)
            @(posedge clk);
        mirror.note_command(op, col, row, kidx, val);
    endtask

    // fill any unwritten entry a read or stamp would touch, then send the item
    task automatic issue(input cmd_t op, input logic [7:0] col, input logic [7:0] row,
                         input logic [KIDX_W-1:0] kidx, input logic [BYTE_W-1:0] val);
        int taps[$];
        int cells[$];
        if (mirror.in_grid(int'(col), int'(row)))
        begin
            if (op == CMD_CELL_RD && !mirror.cell_known[int'(row) * GRID_SIDE + int'(col)])
                send_cmd(CMD_CELL_WR, col, row, KIDX_W'($urandom), BYTE_W'($urandom));
            if (op == CMD_STAMP)
            begin
                mirror.map_window(int'(col), int'(row));
                taps  = mirror.window_taps;
                cells = mirror.window_cells;
                foreach (taps[i])
                    if (!mirror.tap_known[taps[i]])
                        send_cmd(CMD_KERNEL_WR, 8'($urandom), 8'($urandom),
                                 KIDX_W'(taps[i]), BYTE_W'($urandom));
                foreach (cells[i])
                    if (!mirror.cell_known[cells[i]])
                        send_cmd(CMD_CELL_WR, 8'(cells[i] % GRID_SIDE), 8'(cells[i] / GRID_SIDE),
                                 KIDX_W'($urandom), BYTE_W'($urandom));
            end
        end
        send_cmd(op, col, row, kidx, val);
    endtask

    task automatic settle();
        cmd.valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
        mirror.set_register(idx, data);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic en, input logic [HALF_W-1:0] hw,
                                  input logic [BYTE_W-1:0] ceil,
                                  input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] ht);
        settle();
        write_reg(REG_ENABLE, {{(REG_DATA_W-1){1'b0}}, en});
        write_reg(REG_HALF_WIDTH, {{(REG_DATA_W-HALF_W){1'b0}}, hw});
        write_reg(REG_CEILING, {{(REG_DATA_W-BYTE_W){1'b0}}, ceil});
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, ht);
    endtask

    initial
    begin
        int hold;
        res.ready <= 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                res.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 4) - 1;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (res.valid === 1'b1 && res.ready === 1'b1)
                mirror.check_result(res.read_value, res.status);
            if ((res.valid === 1'b1 && res.ready === 1'b1) ||
                (cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
                (cfg.valid === 1'b1 && cfg.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int                en;
        int                hw;
        int                ceil;
        int                w;
        int                ht;
        int                mode;
        int                pick;
        int                cw;
        int                rw;
        int                side;
        cmd_t              op;
        logic [7:0]        col;
        logic [7:0]        row;
        logic [KIDX_W-1:0] kidx;
        logic [BYTE_W-1:0] val;

        idling           = 1'b1;
        rst_n            <= 1'b0;
        cmd.valid        <= 1'b0;
        cmd.command      <= CMD_KERNEL_WR;
        cmd.cell_col     <= '0;
        cmd.cell_row     <= '0;
        cmd.kernel_index <= '0;
        cmd.value        <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= REG_ENABLE;
        cfg.data         <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_KERNEL_WR, 8'h00, 8'h00, 12'd0, 8'hFF);
        issue(CMD_KERNEL_WR, 8'hFF, 8'hFF, 12'd3968, 8'h00);
        issue(CMD_KERNEL_WR, 8'h00, 8'h00, 12'd3969, 8'hAA);
        issue(CMD_KERNEL_WR, 8'h00, 8'h00, 12'hFFF, 8'h55);
        issue(CMD_CELL_WR, 8'h00, 8'h00, 12'h000, 8'h00);
        issue(CMD_CELL_WR, 8'hFF, 8'hFF, 12'hFFF, 8'hFF);
        issue(CMD_STAMP, 8'hFF, 8'hFF, 12'hFFF, 8'hFF);
        issue(CMD_STAMP, 8'h00, 8'h00, 12'h000, 8'h00);
        issue(CMD_CELL_RD, 8'hFF, 8'hFF, 12'hFFF, 8'hFF);
        issue(CMD_CELL_RD, 8'h00, 8'h00, 12'h000, 8'h00);

        apply_settings(1'b1, 5'd1, 8'd10, 9'd3, 9'd2);
        issue(CMD_CELL_WR, 8'd3, 8'd0, 12'd0, 8'h11);
        issue(CMD_CELL_RD, 8'd0, 8'd2, 12'd0, 8'h00);
        issue(CMD_STAMP, 8'd0, 8'd2, 12'd0, 8'h00);
        issue(CMD_CELL_WR, 8'd2, 8'd1, 12'd0, 8'd200);
        issue(CMD_KERNEL_WR, 8'd0, 8'd0, 12'd4, 8'h00);
        issue(CMD_STAMP, 8'd2, 8'd1, 12'd0, 8'h00);
        issue(CMD_CELL_RD, 8'd2, 8'd1, 12'd0, 8'h00);
        issue(CMD_CELL_RD, 8'd1, 8'd0, 12'd0, 8'h00);

        apply_settings(1'b0, 5'd1, 8'd255, 9'd3, 9'd2);
        issue(CMD_STAMP, 8'd1, 8'd1, 12'd0, 8'h00);
        issue(CMD_CELL_RD, 8'd1, 8'd1, 12'd0, 8'h00);

        apply_settings(1'b1, 5'd0, 8'd255, 9'd0, 9'd511);
        issue(CMD_CELL_WR, 8'd0, 8'd0, 12'd0, 8'h5A);
        issue(CMD_CELL_RD, 8'd0, 8'd0, 12'd0, 8'h00);
        issue(CMD_STAMP, 8'd0, 8'd0, 12'd0, 8'h00);
        issue(CMD_KERNEL_WR, 8'd0, 8'd0, 12'd1, 8'hA5);

        apply_settings(1'b1, 5'd0, 8'd0, 9'd300, 9'd256);
        issue(CMD_STAMP, 8'd255, 8'd7, 12'd0, 8'h00);
        issue(CMD_CELL_RD, 8'd255, 8'd7, 12'd0, 8'h00);

        apply_settings(1'b1, 5'd31, 8'd255, 9'd4, 9'd4);
        issue(CMD_STAMP, 8'd2, 8'd2, 12'd0, 8'h00);
        issue(CMD_CELL_RD, 8'd2, 8'd2, 12'd0, 8'h00);
        issue(CMD_STAMP, 8'd0, 8'd3, 12'd0, 8'h00);

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            en   = ($urandom_range(0, 4) != 0) ? 1 : 0;
            mode = $urandom_range(0, 9);
            pick = $urandom_range(0, 3);
            ceil = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255);
            if (mode == 0)
            begin
                w  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 511);
                ht = (w == 0) ? $urandom_range(0, 511) : 0;
                hw = $urandom_range(0, 31);
            end
            else if (mode == 1)
            begin
                w  = $urandom_range(200, 511);
                ht = $urandom_range(200, 511);
                hw = $urandom_range(0, 1);
            end
            else
            begin
                w  = $urandom_range(1, 5);
                ht = $urandom_range(1, 5);
                hw = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
            end
            apply_settings(1'(en), HALF_W'(hw), BYTE_W'(ceil), DIM_W'(w), DIM_W'(ht));
            if (phase == RAND_PHASES - 1)
                idling = 1'b0;

            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 4)
                    op = CMD_KERNEL_WR;
                else if (pick < 8)
                    op = CMD_CELL_WR;
                else if (pick < 13)
                    op = CMD_CELL_RD;
                else
                    op = CMD_STAMP;
                cw = mirror.cols_in_use();
                rw = mirror.rows_in_use();
                if (cw > 0 && rw > 0 && $urandom_range(0, 6) != 0)
                begin
                    col = 8'($urandom_range(0, cw - 1));
                    row = 8'($urandom_range(0, rw - 1));
                end
                else
                begin
                    col = 8'($urandom);
                    row = 8'($urandom);
                end
                side = 2 * int'(mirror.half_width) + 1;
                kidx = ($urandom_range(0, 4) != 0) ? KIDX_W'($urandom_range(0, side * side - 1))
                                                   : KIDX_W'($urandom_range(0, 4095));
                val  = BYTE_W'($urandom);
                issue(op, col, row, kidx, val);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
